// ----- src/lcpd_pkg.sv -----
// ----------------------------------------------------------------------------
// Load cell plateau event detector package
// Shared constants, register codes and the payload and configuration types.
// ----------------------------------------------------------------------------
package lcpd_pkg;

    localparam int WINDOW_DEPTH = 10;
    localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int READING_W = 25;
    localparam int TIME_W = 32;
    localparam int WEIGHT_W = 20;
    localparam int SMOOTH_W = 34;
    localparam int ALPHA_W = 9;
    localparam int GAIN_W = 32;
    localparam int THRESH_W = 16;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;

    localparam logic [CFG_INDEX_W-1:0] REG_SMOOTHING_ALPHA = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_LOAD_READING = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COUNT_GAIN = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_STABLE_TOLERANCE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANGE_THRESHOLD = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_EMPTY_THRESHOLD = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_NOISE_FLOOR = 3'd6;

    typedef enum logic [1:0] {
        EVENT_NONE = 2'd0,
        EVENT_SIP = 2'd1,
        EVENT_REFILL = 2'd2
    } event_kind_t;

    typedef struct packed {
        logic signed [READING_W-1:0] raw_reading;
        logic [TIME_W-1:0] timestamp_ms;
    } sample_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight_cg;
        logic is_stable;
        logic cup_on;
        event_kind_t event_kind;
        logic [WEIGHT_W-1:0] event_amount_cg;
        logic [TIME_W-1:0] event_time_ms;
    } result_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight_cg;
        logic [TIME_W-1:0] timestamp_ms;
    } weight_item_t;

    typedef struct packed {
        logic [ALPHA_W-1:0] smoothing_alpha;
        logic signed [READING_W-1:0] zero_load_reading;
        logic signed [GAIN_W-1:0] count_gain;
        logic [THRESH_W-1:0] stable_tolerance;
        logic [THRESH_W-1:0] change_threshold;
        logic [THRESH_W-1:0] empty_threshold;
        logic [THRESH_W-1:0] noise_floor;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        smoothing_alpha: 9'd154,
        zero_load_reading: -25'sd400,
        count_gain: 32'sd1596393,
        stable_tolerance: 16'd100,
        change_threshold: 16'd200,
        empty_threshold: 16'd100,
        noise_floor: 16'd10
    };

endpackage

// ----- src/load_cell_plateau_event_detector.sv -----
// ----------------------------------------------------------------------------
// Load cell plateau event detector
// Smooths tared load cell samples, converts them to centigrams and reports
// sip and refill events from weight plateaus, one result per sample.
// ----------------------------------------------------------------------------
//   Channel   Direction   Handshake               Payload
//   sample    in          sample_valid/stall      lcpd_pkg::sample_t
//   result    out         result_valid/stall      lcpd_pkg::result_t
//   cfg       in          cfg_write               cfg_index, cfg_data
//
// The front end takes one sample at a time through its average, offset and
// gain multiply steps (the first sample skips the average sum step), then
// hands the weight to a two-entry queue. The back end scans the weight window
// one entry a cycle once the window has filled, then evaluates and decides,
// and so sets the sustained rate. A stalled result holds the back end while
// the front end keeps taking samples until the queue is full. Reset restarts
// the average and clears the window fill state and the plateau state.
// ----------------------------------------------------------------------------
module load_cell_plateau_event_detector (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [lcpd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lcpd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  lcpd_pkg::sample_t                   sample,
    output logic                                result_valid,
    input  logic                                result_stall,
    output lcpd_pkg::result_t                   result
);

    lcpd_pkg::cfg_t cfg_reg;
    lcpd_pkg::cfg_t cfg_next;

    logic push;
    lcpd_pkg::weight_item_t push_item;
    logic queue_full;
    logic pop;
    lcpd_pkg::weight_item_t pop_item;
    logic queue_empty;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                lcpd_pkg::REG_SMOOTHING_ALPHA:
                begin
                    cfg_next.smoothing_alpha = cfg_data[lcpd_pkg::ALPHA_W-1:0];
                end
                lcpd_pkg::REG_ZERO_LOAD_READING:
                begin
                    cfg_next.zero_load_reading = cfg_data[lcpd_pkg::READING_W-1:0];
                end
                lcpd_pkg::REG_COUNT_GAIN:
                begin
                    cfg_next.count_gain = cfg_data[lcpd_pkg::GAIN_W-1:0];
                end
                lcpd_pkg::REG_STABLE_TOLERANCE:
                begin
                    cfg_next.stable_tolerance = cfg_data[lcpd_pkg::THRESH_W-1:0];
                end
                lcpd_pkg::REG_CHANGE_THRESHOLD:
                begin
                    cfg_next.change_threshold = cfg_data[lcpd_pkg::THRESH_W-1:0];
                end
                lcpd_pkg::REG_EMPTY_THRESHOLD:
                begin
                    cfg_next.empty_threshold = cfg_data[lcpd_pkg::THRESH_W-1:0];
                end
                lcpd_pkg::REG_NOISE_FLOOR:
                begin
                    cfg_next.noise_floor = cfg_data[lcpd_pkg::THRESH_W-1:0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= lcpd_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lcpd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .push         (push),
        .push_item    (push_item),
        .queue_full   (queue_full)
    );

    lcpd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (queue_empty)
    );

    lcpd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .empty        (queue_empty),
        .pop          (pop),
        .pop_item     (pop_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ----- src/lcpd_front.sv -----
// ----------------------------------------------------------------------------
// Load cell plateau front end
// Accepts samples, runs the exponential moving average and converts it to centigrams.
// ----------------------------------------------------------------------------
module lcpd_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lcpd_pkg::cfg_t        cfg,
    input  logic                  sample_valid,
    output logic                  sample_stall,
    input  lcpd_pkg::sample_t     sample,
    output logic                  push,
    output lcpd_pkg::weight_item_t push_item,
    input  logic                  queue_full
);

    typedef enum logic [5:0] {
        F_IDLE = 6'b000001,
        F_EMA  = 6'b000010,
        F_SUM  = 6'b000100,
        F_DIFF = 6'b001000,
        F_MUL  = 6'b010000,
        F_PUSH = 6'b100000
    } front_state_t;

    front_state_t state_reg;
    front_state_t state_next;
    logic started_reg;
    logic started_next;

    logic signed [lcpd_pkg::READING_W-1:0] reading_reg;
    logic [lcpd_pkg::TIME_W-1:0] time_reg;
    logic signed [lcpd_pkg::SMOOTH_W-1:0] smoothed_reg;
    logic signed [34:0] prod_new_reg;
    logic signed [43:0] prod_old_reg;
    logic [33:0] mag_reg;
    logic [lcpd_pkg::GAIN_W-1:0] gain_mag_reg;
    logic nonpos_reg;
    logic [63:0] lo_prod_reg;
    logic [33:0] hi_prod_reg;

    logic [lcpd_pkg::ALPHA_W-1:0] alpha_sat;
    logic [lcpd_pkg::ALPHA_W-1:0] alpha_rest;
    logic signed [34:0] mult_new;
    logic signed [43:0] mult_old;
    logic signed [45:0] ema_sum;
    logic signed [35:0] zero_scaled;
    logic signed [35:0] offset;
    logic [35:0] offset_mag;
    logic [lcpd_pkg::GAIN_W-1:0] gain_mag;
    logic nonpos;
    logic [34:0] quot;
    logic [lcpd_pkg::WEIGHT_W-1:0] weight_sat;
    logic accept;

    assign alpha_sat = (cfg.smoothing_alpha > lcpd_pkg::ALPHA_ONE) ?
                       lcpd_pkg::ALPHA_ONE : cfg.smoothing_alpha;
    assign alpha_rest = lcpd_pkg::ALPHA_ONE - alpha_sat;
    assign mult_new = 35'($signed({1'b0, alpha_sat})) * 35'(reading_reg);
    assign mult_old = 44'($signed({1'b0, alpha_rest})) * 44'(smoothed_reg);
    assign ema_sum = (46'(prod_new_reg) <<< 8) + 46'(prod_old_reg) + 46'sd128;

    assign zero_scaled = 36'(cfg.zero_load_reading) <<< 8;
    assign offset = 36'(smoothed_reg) - zero_scaled;
    assign offset_mag = offset[35] ? (~offset + 36'd1) : offset;
    assign gain_mag = cfg.count_gain[lcpd_pkg::GAIN_W-1] ?
                      (~cfg.count_gain + 32'd1) : cfg.count_gain;
    assign nonpos = (offset == 36'sd0) || (cfg.count_gain == 32'sd0) ||
                    (offset[35] != cfg.count_gain[lcpd_pkg::GAIN_W-1]);

    assign quot = 35'(hi_prod_reg) + 35'(lo_prod_reg[63:32]);

    always_comb
    begin
        if (nonpos_reg)
        begin
            weight_sat = '0;
        end
        else if (quot > 35'(lcpd_pkg::WEIGHT_MAX))
        begin
            weight_sat = lcpd_pkg::WEIGHT_MAX;
        end
        else
        begin
            weight_sat = quot[lcpd_pkg::WEIGHT_W-1:0];
        end
    end

    assign sample_stall = (state_reg != F_IDLE);
    assign accept = sample_valid && !sample_stall;
    assign push = (state_reg == F_PUSH) && !queue_full;
    assign push_item.timestamp_ms = time_reg;
    assign push_item.weight_cg =
        (weight_sat < lcpd_pkg::WEIGHT_W'(cfg.noise_floor)) ? '0 : weight_sat;

    always_comb
    begin
        state_next = state_reg;
        started_next = started_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = F_EMA;
                end
            end
            F_EMA:
            begin
                if (started_reg)
                begin
                    state_next = F_SUM;
                end
                else
                begin
                    started_next = 1'b1;
                    state_next = F_DIFF;
                end
            end
            F_SUM:
            begin
                state_next = F_DIFF;
            end
            F_DIFF:
            begin
                state_next = F_MUL;
            end
            F_MUL:
            begin
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!queue_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            started_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            started_reg <= started_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            reading_reg <= sample.raw_reading;
            time_reg <= sample.timestamp_ms;
        end
        if (state_reg == F_EMA)
        begin
            if (started_reg)
            begin
                prod_new_reg <= mult_new;
                prod_old_reg <= mult_old;
            end
            else
            begin
                smoothed_reg <= lcpd_pkg::SMOOTH_W'(reading_reg) <<< 8;
            end
        end
        if (state_reg == F_SUM)
        begin
            smoothed_reg <= ema_sum[8 +: lcpd_pkg::SMOOTH_W];
        end
        if (state_reg == F_DIFF)
        begin
            mag_reg <= offset_mag[33:0];
            gain_mag_reg <= gain_mag;
            nonpos_reg <= nonpos;
        end
        if (state_reg == F_MUL)
        begin
            lo_prod_reg <= 64'(mag_reg[31:0]) * 64'(gain_mag_reg);
            hi_prod_reg <= 34'(mag_reg[33:32]) * 34'(gain_mag_reg);
        end
    end

endmodule

// ----- src/lcpd_queue.sv -----
// ----------------------------------------------------------------------------
// Load cell plateau weight queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module lcpd_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  lcpd_pkg::weight_item_t push_item,
    output logic                   full,
    input  logic                   pop,
    output lcpd_pkg::weight_item_t pop_item,
    output logic                   empty
);

    lcpd_pkg::weight_item_t entry_reg [lcpd_pkg::QUEUE_DEPTH];
    logic [lcpd_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [lcpd_pkg::QPTR_W-1:0] wr_ptr_next;
    logic [lcpd_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [lcpd_pkg::QPTR_W-1:0] rd_ptr_next;
    logic [lcpd_pkg::QCNT_W-1:0] count_reg;
    logic [lcpd_pkg::QCNT_W-1:0] count_next;

    localparam logic [lcpd_pkg::QPTR_W-1:0] PTR_LAST =
        lcpd_pkg::QPTR_W'(lcpd_pkg::QUEUE_DEPTH - 1);

    assign full = (count_reg == lcpd_pkg::QCNT_W'(lcpd_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign pop_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- src/lcpd_back.sv -----
// ----------------------------------------------------------------------------
// Load cell plateau back end
// Keeps the weight window, judges stability and runs the plateau machine.
// ----------------------------------------------------------------------------
module lcpd_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lcpd_pkg::cfg_t         cfg,
    input  logic                   empty,
    output logic                   pop,
    input  lcpd_pkg::weight_item_t pop_item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output lcpd_pkg::result_t      result
);

    typedef enum logic [3:0] {
        B_IDLE   = 4'b0001,
        B_SCAN   = 4'b0010,
        B_EVAL   = 4'b0100,
        B_DECIDE = 4'b1000
    } back_state_t;

    localparam logic [lcpd_pkg::SLOT_W-1:0] SLOT_LAST =
        lcpd_pkg::SLOT_W'(lcpd_pkg::WINDOW_DEPTH - 1);

    back_state_t state_reg;
    back_state_t state_next;
    logic [lcpd_pkg::SLOT_W-1:0] slot_reg;
    logic [lcpd_pkg::SLOT_W-1:0] slot_next;
    logic full_reg;
    logic full_next;
    logic on_reg;
    logic on_next;
    logic awaiting_reg;
    logic awaiting_next;
    logic result_valid_reg;
    logic result_valid_next;

    logic [lcpd_pkg::WEIGHT_W-1:0] window_reg [lcpd_pkg::WINDOW_DEPTH];
    logic [lcpd_pkg::SLOT_W-1:0] scan_reg;
    logic [lcpd_pkg::WEIGHT_W-1:0] lo_reg;
    logic [lcpd_pkg::WEIGHT_W-1:0] hi_reg;
    logic [lcpd_pkg::WEIGHT_W-1:0] weight_reg;
    logic [lcpd_pkg::TIME_W-1:0] time_reg;
    logic stable_reg;
    logic [lcpd_pkg::WEIGHT_W-1:0] last_reg;
    logic [lcpd_pkg::WEIGHT_W-1:0] last_next;
    logic [lcpd_pkg::WEIGHT_W-1:0] before_lift_reg;
    logic [lcpd_pkg::WEIGHT_W-1:0] before_lift_next;
    logic [lcpd_pkg::TIME_W-1:0] lift_time_reg;
    logic [lcpd_pkg::TIME_W-1:0] lift_time_next;
    lcpd_pkg::result_t result_reg;
    lcpd_pkg::result_t result_next;

    logic [lcpd_pkg::WEIGHT_W-1:0] scan_elem;
    logic [lcpd_pkg::WEIGHT_W-1:0] change_thr;
    logic [lcpd_pkg::WEIGHT_W-1:0] empty_thr;
    logic [lcpd_pkg::WEIGHT_W-1:0] diff;
    logic [lcpd_pkg::WEIGHT_W-1:0] lift_mag;
    logic jitter;
    logic load;
    logic window_last;

    assign pop = (state_reg == B_IDLE) && !empty;
    assign window_last = (slot_reg == SLOT_LAST);
    assign scan_elem = window_reg[scan_reg];
    assign change_thr = lcpd_pkg::WEIGHT_W'(cfg.change_threshold);
    assign empty_thr = lcpd_pkg::WEIGHT_W'(cfg.empty_threshold);
    assign diff = (weight_reg > last_reg) ? weight_reg - last_reg : last_reg - weight_reg;
    assign lift_mag = (before_lift_reg > weight_reg) ?
                      before_lift_reg - weight_reg : weight_reg - before_lift_reg;
    assign jitter = (diff < change_thr) && !(!on_reg && (weight_reg > empty_thr));
    assign load = (state_reg == B_DECIDE) && (!result_valid_reg || !result_stall);

    assign result_valid = result_valid_reg;
    assign result = result_reg;

    always_comb
    begin
        state_next = state_reg;
        slot_next = slot_reg;
        full_next = full_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (pop)
                begin
                    slot_next = window_last ? '0 : slot_reg + 1'b1;
                    full_next = full_reg || window_last;
                    state_next = (full_reg || window_last) ? B_SCAN : B_DECIDE;
                end
            end
            B_SCAN:
            begin
                if (scan_reg == SLOT_LAST)
                begin
                    state_next = B_EVAL;
                end
            end
            B_EVAL:
            begin
                state_next = B_DECIDE;
            end
            B_DECIDE:
            begin
                if (load)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        on_next = on_reg;
        awaiting_next = awaiting_reg;
        last_next = last_reg;
        before_lift_next = before_lift_reg;
        lift_time_next = lift_time_reg;
        result_next.weight_cg = weight_reg;
        result_next.is_stable = stable_reg;
        result_next.event_kind = lcpd_pkg::EVENT_NONE;
        result_next.event_amount_cg = '0;
        result_next.event_time_ms = time_reg;
        if (stable_reg && !jitter)
        begin
            if (weight_reg <= empty_thr)
            begin
                if (on_reg)
                begin
                    before_lift_next = last_reg;
                    lift_time_next = time_reg;
                    awaiting_next = 1'b1;
                end
                on_next = 1'b0;
                last_next = '0;
            end
            else if (!on_reg)
            begin
                if (awaiting_reg)
                begin
                    if (lift_mag >= change_thr)
                    begin
                        result_next.event_kind = (before_lift_reg > weight_reg) ?
                                                 lcpd_pkg::EVENT_SIP : lcpd_pkg::EVENT_REFILL;
                        result_next.event_amount_cg = lift_mag;
                        result_next.event_time_ms = lift_time_reg;
                    end
                    awaiting_next = 1'b0;
                end
                on_next = 1'b1;
                last_next = weight_reg;
            end
            else if (diff >= change_thr)
            begin
                result_next.event_kind = (last_reg > weight_reg) ?
                                         lcpd_pkg::EVENT_SIP : lcpd_pkg::EVENT_REFILL;
                result_next.event_amount_cg = diff;
                last_next = weight_reg;
            end
        end
        result_next.cup_on = on_next;
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
        if (load)
        begin
            result_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            slot_reg <= '0;
            full_reg <= 1'b0;
            on_reg <= 1'b0;
            awaiting_reg <= 1'b0;
            last_reg <= '0;
            before_lift_reg <= '0;
            lift_time_reg <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg <= slot_next;
            full_reg <= full_next;
            result_valid_reg <= result_valid_next;
            if (load)
            begin
                on_reg <= on_next;
                awaiting_reg <= awaiting_next;
                last_reg <= last_next;
                before_lift_reg <= before_lift_next;
                lift_time_reg <= lift_time_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            window_reg[slot_reg] <= pop_item.weight_cg;
            weight_reg <= pop_item.weight_cg;
            time_reg <= pop_item.timestamp_ms;
            lo_reg <= pop_item.weight_cg;
            hi_reg <= pop_item.weight_cg;
            scan_reg <= '0;
            stable_reg <= 1'b0;
        end
        if (state_reg == B_SCAN)
        begin
            if (scan_elem < lo_reg)
            begin
                lo_reg <= scan_elem;
            end
            if (scan_elem > hi_reg)
            begin
                hi_reg <= scan_elem;
            end
            scan_reg <= scan_reg + 1'b1;
        end
        if (state_reg == B_EVAL)
        begin
            stable_reg <= ((hi_reg - lo_reg) <= lcpd_pkg::WEIGHT_W'(cfg.stable_tolerance));
        end
        if (load)
        begin
            result_reg <= result_next;
        end
    end

endmodule

// ----- src/lcpd_checker.sv -----
// ----------------------------------------------------------------------------
// Load cell plateau checker
// Port level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module lcpd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              result_valid,
    input logic              result_stall,
    input lcpd_pkg::result_t result
);

    a_stalled_result_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(result))
    ) else $error("Stalled result changed or was dropped.");

    a_event_only_when_stable: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result_valid && !result.is_stable) |-> (result.event_kind == lcpd_pkg::EVENT_NONE)
    ) else $error("Event reported on an unstable sample.");

    a_event_leaves_cup_on: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result_valid && (result.event_kind != lcpd_pkg::EVENT_NONE)) |-> result.cup_on
    ) else $error("Event reported while the scale is empty.");

    a_no_event_no_amount: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result_valid && (result.event_kind == lcpd_pkg::EVENT_NONE)) |->
            (result.event_amount_cg == '0)
    ) else $error("Nonzero amount without an event.");

endmodule

bind load_cell_plateau_event_detector lcpd_checker u_lcpd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
